>>> hw/rtl/hsfp_pkg.sv
// ----------------------------------------------------------------------------
// hsfp_pkg
// shared types and constants of the header sum frame parser
// ----------------------------------------------------------------------------
`default_nettype none

package hsfp_pkg;

  localparam int FRAME_BYTES = 7;
  localparam int POS_W       = 3;

  localparam logic [7:0] HEADER_RESET = 8'hAA;

  // byte positions inside a frame
  localparam logic [POS_W-1:0] POS_HEADER = 3'd0;
  localparam logic [POS_W-1:0] POS_MODE   = 3'd1;
  localparam logic [POS_W-1:0] POS_EX_LO  = 3'd2;
  localparam logic [POS_W-1:0] POS_EX_HI  = 3'd3;
  localparam logic [POS_W-1:0] POS_EY_LO  = 3'd4;
  localparam logic [POS_W-1:0] POS_EY_HI  = 3'd5;
  localparam logic [POS_W-1:0] POS_SUM    = POS_W'(FRAME_BYTES - 1);

  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_BAD  = 1'b1;

  typedef struct packed {
    logic               frame_status;
    logic [7:0]         mode_bits;
    logic signed [15:0] error_x;
    logic signed [15:0] error_y;
    logic [7:0]         sum_byte;
    logic [31:0]        good_frames;
    logic [31:0]        bad_frames;
  } result_t;

  typedef struct packed {
    logic             collecting;
    logic [POS_W-1:0] pos;
  } parse_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/hsfp_collect.sv
// ----------------------------------------------------------------------------
// hsfp_collect
// header hunt, frame byte capture, running sum and frame counters
// ----------------------------------------------------------------------------
`default_nettype none

module hsfp_collect
  import hsfp_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [7:0]    cfg_wdata,
  input  wire logic          take,
  input  wire logic [7:0]    rx_byte,
  output logic               res_valid,
  output result_t            res,
  output parse_status_t      status
);

  logic             collecting;
  logic [POS_W-1:0] pos;
  logic [7:0]       header;
  logic [7:0]       sum;
  logic [7:0]       mode;
  logic [15:0]      ex;
  logic [15:0]      ey;
  logic [31:0]      good_count;
  logic [31:0]      bad_count;

  logic        done;
  logic        bad;
  logic [31:0] good_count_next;
  logic [31:0] bad_count_next;

  assign done            = take && collecting && (pos >= POS_SUM);
  assign bad             = (sum != rx_byte);
  assign good_count_next = good_count + 32'(!bad);
  assign bad_count_next  = bad_count + 32'(bad);

  always_ff @(posedge clk) begin
    if (rst) begin
      header     <= HEADER_RESET;
      collecting <= 1'b0;
      pos        <= POS_HEADER;
      good_count <= '0;
      bad_count  <= '0;
    end else begin
      if (cfg_we) begin
        header <= cfg_wdata;
      end
      if (take) begin
        if (!collecting) begin
          if (rx_byte == header) begin
            collecting <= 1'b1;
            pos        <= POS_MODE;
          end
        end else if (pos < POS_SUM) begin
          pos <= pos + POS_W'(1);
        end else begin
          collecting <= 1'b0;
          pos        <= POS_HEADER;
          good_count <= good_count_next;
          bad_count  <= bad_count_next;
        end
      end
    end
  end

  // frame payload, written at fixed positions
  always_ff @(posedge clk) begin
    if (take) begin
      if (!collecting) begin
        sum <= rx_byte;
      end else if (pos < POS_SUM) begin
        sum <= sum + rx_byte;
        case (pos)
          POS_MODE:  mode       <= rx_byte;
          POS_EX_LO: ex[7:0]    <= rx_byte;
          POS_EX_HI: ex[15:8]   <= rx_byte;
          POS_EY_LO: ey[7:0]    <= rx_byte;
          POS_EY_HI: ey[15:8]   <= rx_byte;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    res_valid        = done;
    res.frame_status = bad ? STATUS_BAD : STATUS_GOOD;
    res.mode_bits    = mode;
    res.error_x      = ex;
    res.error_y      = ey;
    res.sum_byte     = rx_byte;
    res.good_frames  = good_count_next;
    res.bad_frames   = bad_count_next;
  end

  assign status.collecting = collecting;
  assign status.pos        = pos;

endmodule

`default_nettype wire

>>> hw/rtl/hsfp_out_buf.sv
// ----------------------------------------------------------------------------
// hsfp_out_buf
// result register with a skid stage towards the output stream
// ----------------------------------------------------------------------------
`default_nettype none

module hsfp_out_buf
  import hsfp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  result_t      push_data,
  output logic         room,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data,
  output logic         skid_valid
);

  result_t skid_data;
  logic    pop;

  assign pop  = out_valid && out_ready;
  assign room = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/header_sum_frame_parser_core.sv
// ----------------------------------------------------------------------------
// header_sum_frame_parser_core
// fixed-length frame parser with an 8-bit sum checksum
//
// s_axis carries one received byte per beat in tdata. bytes are dropped until
// one equals the header register (cfg_we/cfg_wdata, reset 0xAA); that byte
// and the next six make a seven-byte frame. the last byte is checked against
// the wrapping 8-bit sum of the first six.
// m_axis gives one beat per completed frame: tuser is the status (0 good,
// 1 checksum mismatch), tdata the mode byte, both signed errors, the received
// checksum and the wrapping good and bad frame counters.
// one byte is taken every cycle while s_axis_tready is high. a result goes
// into the result register, or into the skid stage while an earlier result
// waits there, so s_axis_tready stays high while one result waits; it drops
// only when two results are held, and rises in the cycle after m_axis_tready.
// reset (synchronous, rst high) returns to header hunting, clears both
// counters, empties the output and restores the header value.
// ----------------------------------------------------------------------------
`default_nettype none

module header_sum_frame_parser_core
  import hsfp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [7:0]   cfg_wdata,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // rx_byte
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // mode_bits, error_x, error_y, sum_byte, good_frames, bad_frames
  output logic [111:0]      m_axis_tdata,
  output logic [0:0]        m_axis_tuser    // frame_status
);

  logic          take;
  logic          res_valid;
  result_t       res;
  parse_status_t status;
  logic          room;
  result_t       out_data;
  logic          skid_valid;

  assign s_axis_tready = room;
  assign take          = s_axis_tvalid && room;

  hsfp_collect u_collect (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .rx_byte   (s_axis_tdata),
    .res_valid (res_valid),
    .res       (res),
    .status    (status)
  );

  hsfp_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_data  (res),
    .room       (room),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (out_data),
    .skid_valid (skid_valid)
  );

  assign m_axis_tdata = {out_data.bad_frames, out_data.good_frames, out_data.sum_byte,
                         out_data.error_y, out_data.error_x, out_data.mode_bits};
  assign m_axis_tuser = out_data.frame_status;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_axis_tvalid)
    else $error("skid stage holds a result while the output register is empty");

  a_pos_hunting: assert property (@(posedge clk) disable iff (rst)
    !status.collecting |-> status.pos == POS_HEADER)
    else $error("byte position not cleared while hunting");

  a_pos_collecting: assert property (@(posedge clk) disable iff (rst)
    status.collecting |-> (status.pos != POS_HEADER) && (status.pos <= POS_SUM))
    else $error("byte position out of frame while collecting");

  a_result_at_end: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> !status.collecting && m_axis_tvalid)
    else $error("frame end did not return to hunting or lost its beat");

endmodule

`default_nettype wire
